// File: rtl/uart_idle_gap_frame_echo_assert.svh
// Assertion macros shared by the frame echo RTL.
// Depends on nothing; each user names its clock and reset as clock and reset.
`ifndef UART_IDLE_GAP_FRAME_ECHO_ASSERT_SVH
`define UART_IDLE_GAP_FRAME_ECHO_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define UIGFE_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("uigfe: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define UIGFE_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("uigfe: next-cycle check failed");

`endif

// File: rtl/uigfe_pkg.sv
// Shared types and constants of the idle-gap frame echo block.
// Depends on nothing; used by the front end, queue, frame engine, top level and testbench files through scoped names.
package uigfe_pkg;

   // Input opcodes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Configuration register map
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] REG_GAP_TICKS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CHECK_PERIOD = 1'd1;

   // Reset values
   localparam logic [7:0] GAP_TICKS_RST = 8'd5;
   localparam logic [7:0] CHECK_PERIOD_RST = 8'd5;
   localparam logic [7:0] PRIOR_LEN_RST = 8'hff;
   localparam logic [7:0] COUNT_MAX = 8'hff;

   // Classified command passed from front to back
   typedef struct packed {
      logic       is_tick;
      logic [7:0] data;
   } cmd_type;

endpackage

// File: rtl/uigfe_chan_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on nothing.
interface uigfe_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] rx_byte;

   modport source (output valid, output opcode, output rx_byte, input ready);
   modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface uigfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       last;

   modport source (output valid, output tx_byte, output last, input ready);
   modport sink (input valid, input tx_byte, input last, output ready);
endinterface

// File: rtl/uigfe_front.sv
// Front end: accepts request beats, classifies them into commands, holds one.
// Depends on uigfe_pkg and uigfe_req_if.
module uigfe_front (
   input  logic                clock,
   input  logic                reset,
   uigfe_req_if.sink           req_bus,
   output logic                cmd_valid,
   output uigfe_pkg::cmd_type  cmd,
   input  logic                cmd_ready
);

   logic               valid_ff;
   logic               valid_in;
   uigfe_pkg::cmd_type cmd_ff;
   uigfe_pkg::cmd_type cmd_in;
   logic               take;

   assign req_bus.ready = !valid_ff || cmd_ready;
   assign take = req_bus.valid && req_bus.ready;

   // Classify the incoming beat
   always_comb begin
      cmd_in.is_tick = (req_bus.opcode == uigfe_pkg::OP_TICK);
      cmd_in.data = req_bus.rx_byte;
      if (take) begin
         valid_in = 1'b1;
      end else if (cmd_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload until the queue takes it
   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = valid_ff;
   assign cmd = cmd_ff;

endmodule

// File: rtl/uigfe_fifo.sv
// Two-entry command queue between the front end and the frame engine.
// Depends on uigfe_pkg.
module uigfe_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  uigfe_pkg::cmd_type  push_cmd,
   output logic                push_ready,
   output logic                pop_valid,
   output uigfe_pkg::cmd_type  pop_cmd,
   input  logic                pop
);

   uigfe_pkg::cmd_type slot_ff [2];
   logic               wr_ptr_ff;
   logic               wr_ptr_in;
   logic               rd_ptr_ff;
   logic               rd_ptr_in;
   logic [1:0]         count_ff;
   logic [1:0]         count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_cmd = slot_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop && pop_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/uigfe_back.sv
// Frame engine: idle and period counting, frame store, replay of closed frames.
// Depends on uigfe_pkg, uigfe_rsp_if and uart_idle_gap_frame_echo_assert.svh.
`include "uart_idle_gap_frame_echo_assert.svh"

module uigfe_back #(
   parameter int unsigned BUF_DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          gap_ticks,
   input  logic [7:0]          check_period_ticks,
   input  logic                cmd_valid,
   input  uigfe_pkg::cmd_type  cmd,
   output logic                cmd_pop,
   uigfe_rsp_if.source         rsp_bus
);

   localparam int unsigned LW = $clog2(BUF_DEPTH + 1);
   localparam int unsigned AW = $clog2(BUF_DEPTH);

   localparam logic [1:0] S_RUN  = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_LOAD = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [7:0]    idle_ff, idle_in;
   logic          in_frame_ff, in_frame_in;
   logic [LW-1:0] len_ff, len_in;
   logic [7:0]    prior_ff, prior_in;
   logic [7:0]    period_ff, period_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [7:0]    rd_data_ff;
   logic [7:0]    mem [BUF_DEPTH];
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_byte_ff;
   logic          out_last_ff;
   logic          load;
   logic          load_last;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic          open_frame;
   logic [LW-1:0] len_base;
   logic [7:0]    period_sat;
   logic [7:0]    limit;

   assign cmd_pop = cmd_valid && (state_ff == S_RUN);
   assign load = (state_ff == S_LOAD) && (!out_valid_ff || rsp_bus.ready);
   assign load_last = (LW'(rd_idx_ff) + LW'(1)) == len_ff;
   assign open_frame = idle_ff > gap_ticks;
   assign len_base = open_frame ? '0 : len_ff;
   assign period_sat = (period_ff == uigfe_pkg::COUNT_MAX) ? period_ff : period_ff + 8'd1;
   assign limit = (check_period_ticks == 8'd0) ? 8'd1 : check_period_ticks;

   // Execute one command, or step the replay
   always_comb begin
      state_in = state_ff;
      idle_in = idle_ff;
      in_frame_in = in_frame_ff;
      len_in = len_ff;
      prior_in = prior_ff;
      period_in = period_ff;
      rd_idx_in = rd_idx_ff;
      mem_we = 1'b0;
      mem_waddr = len_base[AW-1:0];
      case (state_ff)
         S_RUN: begin
            if (cmd_pop && !cmd.is_tick) begin
               // Byte: maybe open a frame, then store or wrap
               idle_in = 8'd0;
               if (open_frame) begin
                  in_frame_in = 1'b1;
                  period_in = 8'd0;
               end
               if (len_base == LW'(BUF_DEPTH)) begin
                  len_in = '0;
               end else begin
                  mem_we = 1'b1;
                  len_in = len_base + LW'(1);
               end
            end else if (cmd_pop) begin
               // Tick: count idle time, check growth of an open frame
               if (idle_ff != uigfe_pkg::COUNT_MAX) begin
                  idle_in = idle_ff + 8'd1;
               end
               if (in_frame_ff) begin
                  if (period_sat < limit) begin
                     period_in = period_sat;
                  end else begin
                     period_in = 8'd0;
                     prior_in = 8'(len_ff);
                     if (8'(len_ff) == prior_ff) begin
                        in_frame_in = 1'b0;
                        rd_idx_in = '0;
                        if (len_ff != '0) begin
                           state_in = S_READ;
                        end
                     end
                  end
               end
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (load) begin
               if (load_last) begin
                  state_in = S_RUN;
               end else begin
                  rd_idx_in = rd_idx_ff + AW'(1);
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
   end

   // Output register: load a replayed byte, drop it once taken
   always_comb begin
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RUN;
         idle_ff <= 8'd0;
         in_frame_ff <= 1'b0;
         len_ff <= '0;
         prior_ff <= uigfe_pkg::PRIOR_LEN_RST;
         period_ff <= 8'd0;
         rd_idx_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idle_ff <= idle_in;
         in_frame_ff <= in_frame_in;
         len_ff <= len_in;
         prior_ff <= prior_in;
         period_ff <= period_in;
         rd_idx_ff <= rd_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Frame store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= cmd.data;
      end
      rd_data_ff <= mem[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff <= rd_data_ff;
         out_last_ff <= load_last;
      end
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.tx_byte = out_byte_ff;
   assign rsp_bus.last = out_last_ff;

   `UIGFE_ASSERT_NOW(a_replay_closed, state_ff != S_RUN, !in_frame_ff)
   `UIGFE_ASSERT_NOW(a_len_bound, 1'b1, len_ff <= LW'(BUF_DEPTH))
   `UIGFE_ASSERT_NOW(a_replay_nonempty, state_ff != S_RUN, len_ff != '0)
   `UIGFE_ASSERT_NEXT(a_last_ends_replay, load && load_last, state_ff == S_RUN)

endmodule

// File: rtl/uart_idle_gap_frame_echo.sv
// Top level of the idle-gap frame echo: configuration registers and wiring.
// Depends on uigfe_pkg, uigfe_chan_if, uigfe_front, uigfe_fifo and uigfe_back.
//
//   channel  direction  payload                 handshake
//   req_bus  in         opcode, rx_byte         valid/ready
//   rsp_bus  out        tx_byte, last           valid/ready
//   csr_*    in         csr_index, csr_wdata    csr_wr_en, no wait
//
// A request beat passes the input register and the two-entry queue before
// the frame engine executes it; the engine takes one command a cycle while
// no replay is running. A closed frame of N bytes is replayed byte by byte
// (store read, then output register load), holding off further commands.
// Reset is synchronous; no clearing pass is needed. A stalled response holds
// the replay, and the queue then fills and deasserts req_bus.ready.
module uart_idle_gap_frame_echo #(
   parameter int unsigned BUF_DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   uigfe_req_if.sink                            req_bus,
   uigfe_rsp_if.source                          rsp_bus,
   input  logic                                 csr_wr_en,
   input  logic [uigfe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [uigfe_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [7:0]         gap_ticks_ff;
   logic [7:0]         check_period_ff;
   logic               front_valid;
   uigfe_pkg::cmd_type front_cmd;
   logic               front_ready;
   logic               queue_valid;
   uigfe_pkg::cmd_type queue_cmd;
   logic               queue_pop;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ticks_ff <= uigfe_pkg::GAP_TICKS_RST;
         check_period_ff <= uigfe_pkg::CHECK_PERIOD_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            uigfe_pkg::REG_GAP_TICKS: gap_ticks_ff <= csr_wdata;
            uigfe_pkg::REG_CHECK_PERIOD: check_period_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   uigfe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cmd_valid (front_valid),
      .cmd       (front_cmd),
      .cmd_ready (front_ready)
   );

   uigfe_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_cmd   (front_cmd),
      .push_ready (front_ready),
      .pop_valid  (queue_valid),
      .pop_cmd    (queue_cmd),
      .pop        (queue_pop)
   );

   uigfe_back #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .gap_ticks          (gap_ticks_ff),
      .check_period_ticks (check_period_ff),
      .cmd_valid          (queue_valid),
      .cmd                (queue_cmd),
      .cmd_pop            (queue_pop),
      .rsp_bus            (rsp_bus)
   );

endmodule

// File: tb/uart_idle_gap_frame_echo_chk.sv
// Checker for the idle-gap frame echo: predicts replayed frames and compares them.
// Depends on uigfe_pkg and the channel interfaces in uigfe_chan_if.
`timescale 1ns / 1ps

module uart_idle_gap_frame_echo_chk (
   input  logic                             clock,
   input  logic                             reset,
   uigfe_req_if                             req_bus,
   uigfe_rsp_if                             rsp_bus,
   input  logic                             csr_wr_en,
   input  logic [uigfe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [uigfe_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int unsigned                      mismatch_count,
   output int unsigned                      echo_outstanding
);

   localparam int unsigned FRAME_DEPTH = 64;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
   } echo_beat_type;

   // Predictor copy of configuration and frame state
   logic [7:0] gap_cfg;
   logic [7:0] period_cfg;
   logic [7:0] idle_cnt;
   logic       frame_open;
   logic [6:0] frame_len;
   logic [7:0] prior_len;
   logic [7:0] period_cnt;
   logic [7:0] frame_bytes [FRAME_DEPTH];

   echo_beat_type echo_q [$];

   task automatic report_mismatch(input string what, input logic [7:0] want,
                                  input logic [7:0] got);
      $display("%0t: %s: expected %02h, got %02h", $time, what, want, got);
      mismatch_count++;
   endtask

   // Store a received byte, opening a new frame after a long enough gap
   task automatic absorb_byte(input logic [7:0] data);
      if (idle_cnt > gap_cfg) begin
         frame_open = 1'b1;
         frame_len  = '0;
         period_cnt = '0;
      end
      idle_cnt = '0;
      if (frame_len >= FRAME_DEPTH) begin
         frame_len = '0;
      end else begin
         frame_bytes[frame_len[5:0]] = data;
         frame_len = frame_len + 7'd1;
      end
   endtask

   // Advance the counters; on a check with no growth, close and queue the replay
   task automatic absorb_tick();
      logic [7:0] limit;
      limit = (period_cfg == 8'd0) ? 8'd1 : period_cfg;
      if (idle_cnt != uigfe_pkg::COUNT_MAX) idle_cnt = idle_cnt + 8'd1;
      if (!frame_open) return;
      if (period_cnt != uigfe_pkg::COUNT_MAX) period_cnt = period_cnt + 8'd1;
      if (period_cnt < limit) return;
      period_cnt = '0;
      if ({1'b0, frame_len} == prior_len) begin
         frame_open = 1'b0;
         for (int unsigned k = 0; k < frame_len; k++)
            echo_q.push_back(echo_beat_type'{tx_byte: frame_bytes[k],
                                             last: (k + 1 == frame_len)});
      end
      prior_len = {1'b0, frame_len};
   endtask

   always @(posedge clock) begin
      echo_beat_type want;
      if (reset) begin
         gap_cfg        = uigfe_pkg::GAP_TICKS_RST;
         period_cfg     = uigfe_pkg::CHECK_PERIOD_RST;
         idle_cnt       = '0;
         frame_open     = 1'b0;
         frame_len      = '0;
         prior_len      = uigfe_pkg::PRIOR_LEN_RST;
         period_cnt     = '0;
         mismatch_count = 0;
         echo_q.delete();
      end else begin
         // Track register writes
         if (csr_wr_en) begin
            if (csr_index == uigfe_pkg::REG_GAP_TICKS) gap_cfg = csr_wdata;
            else if (csr_index == uigfe_pkg::REG_CHECK_PERIOD) period_cfg = csr_wdata;
         end

         // Predict on each accepted request beat
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.opcode == uigfe_pkg::OP_TICK) absorb_tick();
            else absorb_byte(req_bus.rx_byte);
         end

         // Compare each accepted echo beat with the oldest prediction
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (echo_q.size() == 0) begin
               report_mismatch("echo beat with nothing pending", 8'h00, rsp_bus.tx_byte);
            end else begin
               want = echo_q.pop_front();
               if (rsp_bus.tx_byte !== want.tx_byte)
                  report_mismatch("tx_byte", want.tx_byte, rsp_bus.tx_byte);
               if (rsp_bus.last !== want.last)
                  report_mismatch("last", {7'd0, want.last}, {7'd0, rsp_bus.last});
            end
         end
      end
      echo_outstanding <= echo_q.size();
   end

endmodule

// File: tb/uart_idle_gap_frame_echo_tb.sv
// Top of the idle-gap frame echo testbench: clock, reset, stimulus and verdict.
// Depends on uigfe_pkg, uigfe_chan_if, the block and uart_idle_gap_frame_echo_chk.
`timescale 1ns / 1ps

module uart_idle_gap_frame_echo_tb;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_wr_en;
   logic [uigfe_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [uigfe_pkg::CSR_DATA_W-1:0] csr_wdata;
   int unsigned                      mismatch_count;
   int unsigned                      echo_outstanding;
   int unsigned                      send_idle_pct;
   int unsigned                      sink_stall_pct;
   int unsigned                      beats_sent;
   logic [7:0]                       gap_set;
   logic [7:0]                       period_set;

   uigfe_req_if req_bus ();
   uigfe_rsp_if rsp_bus ();

   uart_idle_gap_frame_echo u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   uart_idle_gap_frame_echo_chk u_chk (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .echo_outstanding (echo_outstanding)
   );

   always #10 clock = ~clock;

   // Stall the echo side at random
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
   end

   // Offer one request beat, idling first at random; hold valid for the next beat
   task automatic send_beat(input logic op, input logic [7:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.opcode  <= op;
      req_bus.rx_byte <= data;
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
   endtask

   task automatic send_ticks(input int unsigned n);
      repeat (n) send_beat(uigfe_pkg::OP_TICK, 8'($urandom));
   endtask

   // Usually a gap, then bytes with the odd stray tick, then enough ticks for two checks
   task automatic send_frame(input int unsigned len);
      int unsigned limit;
      limit = (period_set == 8'd0) ? 1 : period_set;
      if ($urandom_range(4) != 0) send_ticks(gap_set + 1 + $urandom_range(2));
      for (int unsigned k = 0; k < len; k++) begin
         send_beat(uigfe_pkg::OP_BYTE, 8'($urandom));
         if ($urandom_range(9) == 0) send_ticks(1);
      end
      send_ticks(2 * limit + $urandom_range(limit));
   endtask

   // Mostly well-formed frames, the rest loose beats of either kind
   task automatic run_mix(input int unsigned beats);
      int unsigned start;
      start = beats_sent;
      while (beats_sent - start < beats) begin
         if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 4)) send_beat(1'($urandom), 8'($urandom));
         else
            send_frame($urandom_range(1, 8));
      end
   endtask

   // Drop valid and hold off until every predicted beat has come back
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (echo_outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic program_regs(input logic [7:0] gap, input logic [7:0] period);
      settle();
      csr_wr_en <= 1'b1;
      csr_index <= uigfe_pkg::REG_GAP_TICKS;
      csr_wdata <= gap;
      @(posedge clock);
      csr_index <= uigfe_pkg::REG_CHECK_PERIOD;
      csr_wdata <= period;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      gap_set    = gap;
      period_set = period;
   endtask

   initial begin
      req_bus.valid   <= 1'b0;
      req_bus.opcode  <= uigfe_pkg::OP_BYTE;
      req_bus.rx_byte <= 8'h00;
      csr_wr_en       <= 1'b0;
      csr_index       <= uigfe_pkg::REG_GAP_TICKS;
      csr_wdata       <= 8'h00;
      send_idle_pct   = 0;
      sink_stall_pct  = 0;
      beats_sent      = 0;
      gap_set         = uigfe_pkg::GAP_TICKS_RST;
      period_set      = uigfe_pkg::CHECK_PERIOD_RST;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Bytes outside a frame, then a gap, a frame of extreme bytes and its close
      send_beat(uigfe_pkg::OP_BYTE, 8'h00);
      send_beat(uigfe_pkg::OP_BYTE, 8'hff);
      send_ticks(6);
      send_beat(uigfe_pkg::OP_BYTE, 8'ha5);
      send_beat(uigfe_pkg::OP_BYTE, 8'h5a);
      send_beat(uigfe_pkg::OP_BYTE, 8'hff);
      send_beat(uigfe_pkg::OP_BYTE, 8'h00);
      send_ticks(10);

      // Random traffic under each idling pattern
      run_mix(8);
      program_regs(8'd0, 8'd1);
      send_idle_pct = 85;
      run_mix(8);
      program_regs(8'd3, 8'd0);
      send_idle_pct  = 0;
      sink_stall_pct = 85;
      run_mix(8);
      program_regs(8'd2, 8'd4);
      send_idle_pct  = 37;
      sink_stall_pct = 37;
      run_mix(8);

      // Store limit: fill, drop at full length, then restart from the bottom
      send_frame(66);

      settle();
      if (mismatch_count == 0 && echo_outstanding == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/uigfe_pkg.sv
rtl/uigfe_chan_if.sv
rtl/uigfe_front.sv
rtl/uigfe_fifo.sv
rtl/uigfe_back.sv
rtl/uart_idle_gap_frame_echo.sv
tb/uart_idle_gap_frame_echo_chk.sv
tb/uart_idle_gap_frame_echo_tb.sv
